// ===== rtl/jeo_pkg.sv =====
// Shared constants and controller/datapath interface types for the Josephus block.
`default_nettype none

package jeo_pkg;

  // Largest circle the block supports.
  localparam int MAX_PEOPLE = 64;

  // Field and counter widths.
  localparam int POS_W  = $clog2(MAX_PEOPLE);
  localparam int CNT_W  = 7;
  localparam int STEP_W = 10;
  localparam int REM_W  = CNT_W + 1;
  localparam int IDX_W  = 4;

  // Reset values of the configuration registers.
  localparam logic [CNT_W-1:0]  CIRCLE_SIZE_RESET = 7'd7;
  localparam logic [STEP_W-1:0] STEP_COUNT_RESET  = 10'd3;

  // Register indexes on the configuration port.
  localparam logic REG_CIRCLE_SIZE = 1'b0;
  localparam logic REG_STEP_COUNT  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic count;
    logic mod_start;
    logic mod_step;
    logic walk_start;
    logic walk_step;
    logic emit_empty;
    logic emit_remove;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic size_zero;
    logic count_done;
    logic is_empty;
    logic mod_done;
    logic hit;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/jeo_datapath.sv =====
// Datapath: removal map, present count, remainder unit, circular walk and result registers.
`default_nettype none

module jeo_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire jeo_pkg::cmd_t                  cmd,
  input  wire logic                           restart,
  input  wire logic [jeo_pkg::CNT_W-1:0]      circle_size,
  input  wire logic [jeo_pkg::STEP_W-1:0]     step_count,
  output jeo_pkg::status_t                    status,
  output logic [jeo_pkg::CNT_W-1:0]           removed_person,
  output logic                                last_removal,
  output logic                                circle_empty,
  output logic                                done
);

  // Architectural state.
  logic [jeo_pkg::MAX_PEOPLE-1:0] removed_map;
  logic [jeo_pkg::POS_W-1:0]      search_start;
  logic [jeo_pkg::CNT_W-1:0]      removed_total;

  // Per-request working registers.
  logic [jeo_pkg::CNT_W-1:0]      n_lat;
  logic [jeo_pkg::STEP_W-1:0]     k_minus1;
  logic [jeo_pkg::POS_W-1:0]      pos;
  logic [jeo_pkg::CNT_W-1:0]      present;
  logic [jeo_pkg::REM_W-1:0]      rem;
  logic [jeo_pkg::IDX_W-1:0]      mod_idx;

  logic [jeo_pkg::CNT_W-1:0]      n_eff;
  logic [jeo_pkg::STEP_W-1:0]     k_eff;
  logic                           pos_present;
  logic [jeo_pkg::CNT_W-1:0]      pos_inc;
  logic [jeo_pkg::POS_W-1:0]      pos_wrap;
  logic [jeo_pkg::REM_W-1:0]      rem_shift;
  logic [jeo_pkg::REM_W-1:0]      rem_next;
  logic [jeo_pkg::CNT_W-1:0]      total_inc;

  // Saturate the size and treat a zero step as one.
  assign n_eff = (circle_size > jeo_pkg::CNT_W'(jeo_pkg::MAX_PEOPLE)) ?
                 jeo_pkg::CNT_W'(jeo_pkg::MAX_PEOPLE) : circle_size;
  assign k_eff = (step_count == '0) ? '0 : step_count - jeo_pkg::STEP_W'(1);

  // Position helpers shared by the count and the walk.
  assign pos_present = ~removed_map[pos];
  assign pos_inc     = {1'b0, pos} + jeo_pkg::CNT_W'(1);
  assign pos_wrap    = (pos_inc == n_lat) ? '0 : pos_inc[jeo_pkg::POS_W-1:0];

  // One restoring step of (k-1) mod present.
  assign rem_shift = {rem[jeo_pkg::REM_W-2:0], k_minus1[mod_idx]};
  assign rem_next  = (rem_shift >= {1'b0, present}) ? rem_shift - {1'b0, present} : rem_shift;

  assign total_inc = removed_total + jeo_pkg::CNT_W'(1);

  // Status toward the controller.
  always_comb begin
    status.size_zero  = (n_lat == '0);
    status.count_done = (pos_inc == n_lat);
    status.is_empty   = (removed_total >= n_lat) || (present == '0);
    status.mod_done   = (mod_idx == '0);
    status.hit        = pos_present && (rem == '0);
  end

  // Architectural state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      removed_map   <= '0;
      search_start  <= '0;
      removed_total <= jeo_pkg::CIRCLE_SIZE_RESET;
    end else begin
      if (cmd.load && restart) begin
        removed_map   <= '0;
        search_start  <= '0;
        removed_total <= '0;
      end
      if (cmd.emit_remove) begin
        removed_map[pos] <= 1'b1;
        search_start     <= pos + jeo_pkg::POS_W'(1);
        removed_total    <= total_inc;
      end
    end
  end

  // Count, remainder and walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_lat    <= n_eff;
      k_minus1 <= k_eff;
      pos      <= '0;
      present  <= '0;
    end
    if (cmd.count) begin
      present <= present + jeo_pkg::CNT_W'(pos_present);
      pos     <= pos_inc[jeo_pkg::POS_W-1:0];
    end
    if (cmd.mod_start) begin
      rem     <= '0;
      mod_idx <= jeo_pkg::IDX_W'(jeo_pkg::STEP_W - 1);
    end
    if (cmd.mod_step) begin
      rem     <= rem_next;
      mod_idx <= mod_idx - jeo_pkg::IDX_W'(1);
    end
    if (cmd.walk_start) begin
      pos <= ({1'b0, search_start} >= n_lat) ? '0 : search_start;
    end
    if (cmd.walk_step) begin
      if (pos_present) begin
        rem <= rem - jeo_pkg::REM_W'(1);
      end
      pos <= pos_wrap;
    end
  end

  // Result registers; the strobe lasts one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit_empty || cmd.emit_remove;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_empty) begin
      removed_person <= '0;
      last_removal   <= 1'b0;
      circle_empty   <= 1'b1;
    end else if (cmd.emit_remove) begin
      removed_person <= pos_inc;
      last_removal   <= (present == jeo_pkg::CNT_W'(1)) || (total_inc >= n_lat);
      circle_empty   <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jeo_ctrl.sv =====
// Controller state machine that sequences count, remainder and walk phases.
`default_nettype none

module jeo_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire jeo_pkg::status_t status,
  output logic                  busy,
  output jeo_pkg::cmd_t         cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COUNT = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_MOD   = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign busy = (state != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        if (status.size_zero) begin
          cmd.emit_empty = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.count = 1'b1;
          if (status.count_done) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (status.is_empty) begin
          cmd.emit_empty = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.mod_start = 1'b1;
          state_next    = S_MOD;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (status.mod_done) begin
          cmd.walk_start = 1'b1;
          state_next     = S_WALK;
        end
      end
      S_WALK: begin
        if (status.hit) begin
          cmd.emit_remove = 1'b1;
          state_next      = S_IDLE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/josephus_elimination_order.sv =====
// Top level of the Josephus elimination order block with its configuration registers.
`default_nettype none

// Each beat accepted on start (while busy is low) yields one result beat, marked by done for
// one cycle; the receiver cannot stall it. A request scans the n seats to count the people
// still present, tests for an empty circle, forms the bit-serial remainder of (k-1) by that
// count, and then walks stepping one seat a cycle (n is circle_size saturated at 64). The walk
// length depends on the saved seat and the map. The next beat can be accepted at the edge that
// ends the cycle in which done is shown.
module josephus_elimination_order (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       restart,
  output logic                            done,
  output logic [jeo_pkg::CNT_W-1:0]       removed_person,
  output logic                            last_removal,
  output logic                            circle_empty,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [jeo_pkg::CNT_W-1:0]  circle_size;
  logic [jeo_pkg::STEP_W-1:0] step_count;
  logic                       cfg_write;
  jeo_pkg::cmd_t              cmd;
  jeo_pkg::status_t           status;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      circle_size <= jeo_pkg::CIRCLE_SIZE_RESET;
      step_count  <= jeo_pkg::STEP_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        jeo_pkg::REG_CIRCLE_SIZE: circle_size <= pwdata[jeo_pkg::CNT_W-1:0];
        jeo_pkg::REG_STEP_COUNT:  step_count  <= pwdata[jeo_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[2])
      jeo_pkg::REG_CIRCLE_SIZE: prdata = {{(32-jeo_pkg::CNT_W){1'b0}}, circle_size};
      jeo_pkg::REG_STEP_COUNT:  prdata = {{(32-jeo_pkg::STEP_W){1'b0}}, step_count};
      default:                  prdata = '0;
    endcase
  end

  jeo_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  jeo_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .restart        (restart),
    .circle_size    (circle_size),
    .step_count     (step_count),
    .status         (status),
    .removed_person (removed_person),
    .last_removal   (last_removal),
    .circle_empty   (circle_empty),
    .done           (done)
  );

endmodule

`default_nettype wire

// ===== tb/josephus_elimination_order_tb.sv =====
// Self-checking testbench for the Josephus elimination order block.
`default_nettype none

module josephus_elimination_order_tb;

  // One result beat of the block.
  typedef struct packed {
    logic [jeo_pkg::CNT_W-1:0] person;
    logic                      last;
    logic                      empty;
  } removal_t;

  // A row of the directed plan is either a register write or a request.
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic        reg_idx;
    logic [31:0] value;
    logic        fresh;
    logic        typed;
    removal_t    want;
  } plan_row_t;

  localparam removal_t NONE_LEFT = '{person: '0, last: 1'b0, empty: 1'b1};
  localparam removal_t UNTYPED = '0;
  localparam int PLAN_LEN = 36;
  localparam int SETTLE_CYCLES = 2 * jeo_pkg::MAX_PEOPLE + 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEMS_PER_MODE = 550;

  // Directed plan: the expected beat is typed in only where it is obvious.
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // Circle is empty right after reset.
    '{ROW_ITEM, 1'b0, 32'd0, 1'b0, 1'b1, NONE_LEFT},
    // Reset setting n=7, k=3: the full elimination order, first and last typed.
    '{ROW_ITEM, 1'b0, 32'd0, 1'b1, 1'b1, '{7'd3, 1'b0, 1'b0}},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b0, 1'b0, UNTYPED},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b0, 1'b0, UNTYPED},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b0, 1'b0, UNTYPED},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b0, 1'b0, UNTYPED},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b0, 1'b0, UNTYPED},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b0, 1'b1, '{7'd4, 1'b1, 1'b0}},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b0, 1'b1, NONE_LEFT},
    // A circle of size zero is always empty.
    '{ROW_CFG,  jeo_pkg::REG_CIRCLE_SIZE, 32'd0, 1'b0, 1'b0, UNTYPED},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b1, 1'b1, NONE_LEFT},
    // One person with the largest step.
    '{ROW_CFG,  jeo_pkg::REG_CIRCLE_SIZE, 32'd1, 1'b0, 1'b0, UNTYPED},
    '{ROW_CFG,  jeo_pkg::REG_STEP_COUNT, 32'd1023, 1'b0, 1'b0, UNTYPED},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b1, 1'b1, '{7'd1, 1'b1, 1'b0}},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b0, 1'b1, NONE_LEFT},
    // Size above range saturates to the maximum; step zero acts as one.
    '{ROW_CFG,  jeo_pkg::REG_CIRCLE_SIZE, 32'd127, 1'b0, 1'b0, UNTYPED},
    '{ROW_CFG,  jeo_pkg::REG_STEP_COUNT, 32'd0, 1'b0, 1'b0, UNTYPED},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b1, 1'b1, '{7'd1, 1'b0, 1'b0}},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b0, 1'b1, '{7'd2, 1'b0, 1'b0}},
    // Full circle, then shrink it so the saved position lies outside.
    '{ROW_CFG,  jeo_pkg::REG_CIRCLE_SIZE, 32'd64, 1'b0, 1'b0, UNTYPED},
    '{ROW_CFG,  jeo_pkg::REG_STEP_COUNT, 32'd40, 1'b0, 1'b0, UNTYPED},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b1, 1'b1, '{7'd40, 1'b0, 1'b0}},
    '{ROW_CFG,  jeo_pkg::REG_CIRCLE_SIZE, 32'd10, 1'b0, 1'b0, UNTYPED},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b0, 1'b0, UNTYPED},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b0, 1'b0, UNTYPED},
    // Largest step on the saturated circle wraps many times.
    '{ROW_CFG,  jeo_pkg::REG_STEP_COUNT, 32'd1023, 1'b0, 1'b0, UNTYPED},
    '{ROW_CFG,  jeo_pkg::REG_CIRCLE_SIZE, 32'd127, 1'b0, 1'b0, UNTYPED},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b1, 1'b0, UNTYPED},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b0, 1'b0, UNTYPED},
    // Shrinking below the removal count empties the circle at once.
    '{ROW_CFG,  jeo_pkg::REG_CIRCLE_SIZE, 32'd5, 1'b0, 1'b0, UNTYPED},
    '{ROW_CFG,  jeo_pkg::REG_STEP_COUNT, 32'd1, 1'b0, 1'b0, UNTYPED},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b1, 1'b1, '{7'd1, 1'b0, 1'b0}},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b0, 1'b0, UNTYPED},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b0, 1'b0, UNTYPED},
    '{ROW_CFG,  jeo_pkg::REG_CIRCLE_SIZE, 32'd2, 1'b0, 1'b0, UNTYPED},
    '{ROW_ITEM, 1'b0, 32'd0, 1'b0, 1'b1, NONE_LEFT}
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       restart = 1'b0;
  logic                       busy;
  logic                       done;
  logic [jeo_pkg::CNT_W-1:0]  removed_person;
  logic                       last_removal;
  logic                       circle_empty;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [2:0]                 paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  // Predictor copy of the circle and of the registers.
  logic [jeo_pkg::MAX_PEOPLE-1:0] seat_gone = '0;
  logic [jeo_pkg::POS_W-1:0]      next_seat = '0;
  logic [jeo_pkg::CNT_W-1:0]      gone_count = jeo_pkg::CIRCLE_SIZE_RESET;
  logic [jeo_pkg::CNT_W-1:0]      cfg_size = jeo_pkg::CIRCLE_SIZE_RESET;
  logic [jeo_pkg::STEP_W-1:0]     cfg_step = jeo_pkg::STEP_COUNT_RESET;

  removal_t removals_due[$];
  removal_t head_due;
  int       mismatches = 0;
  int       items_sent = 0;
  int       sender_idle = 27;
  int       quiet_cycles = 0;

  josephus_elimination_order DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .restart(restart),
    .done(done),
    .removed_person(removed_person),
    .last_removal(last_removal),
    .circle_empty(circle_empty),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  // Works out the removal for one request and advances the circle.
  function automatic void predict_removal(input logic fresh, output removal_t res);
    int n;
    int k;
    int present;
    int tgt;
    int s;
    int pos;
    int j;
    n = (cfg_size > jeo_pkg::MAX_PEOPLE) ? jeo_pkg::MAX_PEOPLE : int'(cfg_size);
    k = (cfg_step == 0) ? 1 : int'(cfg_step);
    if (fresh) begin
      seat_gone = '0;
      next_seat = '0;
      gone_count = '0;
    end
    present = 0;
    for (j = 0; j < n; j++) begin
      if (!seat_gone[j]) present++;
    end
    res = '0;
    if (gone_count >= n || present == 0) begin
      res.empty = 1'b1;
      return;
    end
    // Walk from the saved seat to the k-th person still present.
    tgt = (k - 1) % present;
    s = next_seat;
    if (s >= n) s = 0;
    pos = 0;
    for (j = 0; j < n; j++) begin
      pos = s + j;
      if (pos >= n) pos -= n;
      if (!seat_gone[pos]) begin
        if (tgt == 0) break;
        tgt--;
      end
    end
    seat_gone[pos] = 1'b1;
    next_seat = jeo_pkg::POS_W'(pos + 1);
    gone_count = gone_count + 1'b1;
    res.person = jeo_pkg::CNT_W'(pos + 1);
    res.last = (present == 1 || gone_count >= n);
  endfunction

  // Counts a mismatch and reports the first few of them.
  function automatic void note_mismatch(input removal_t want, input removal_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch: expected person %0d last %0b empty %0b, %s %0d last %0b empty %0b",
               want.person, want.last, want.empty, "got person",
               got.person, got.last, got.empty);
  endfunction

  // Sends one request beat and records its expected result once it is taken.
  task automatic send_item(input logic fresh, input logic typed, input removal_t want);
    removal_t res;
    while ($urandom_range(0, 99) < sender_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    restart <= fresh;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_removal(fresh, res);
    if (typed) res = want;
    removals_due = {removals_due, res};
    items_sent++;
  endtask

  // Waits until the block is idle, then writes one register over the APB port.
  task automatic program_register(input logic idx, input logic [31:0] val);
    start <= 1'b0;
    while (removals_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == jeo_pkg::REG_CIRCLE_SIZE) cfg_size = val[jeo_pkg::CNT_W-1:0];
    else cfg_step = val[jeo_pkg::STEP_W-1:0];
  endtask

  // Picks a new circle size and step, mostly small circles.
  task automatic retune();
    int c;
    logic [jeo_pkg::CNT_W-1:0]  sz;
    logic [jeo_pkg::STEP_W-1:0] st;
    c = $urandom_range(0, 99);
    if (c < 70) sz = jeo_pkg::CNT_W'($urandom_range(1, 12));
    else if (c < 88) sz = jeo_pkg::CNT_W'($urandom_range(13, 64));
    else if (c < 95) sz = jeo_pkg::CNT_W'($urandom_range(65, 127));
    else sz = '0;
    c = $urandom_range(0, 99);
    if (c < 45) st = jeo_pkg::STEP_W'($urandom_range(0, 6));
    else if (c < 85) st = jeo_pkg::STEP_W'($urandom_range(0, 1023));
    else if (c < 93) st = 10'd1023;
    else st = 10'd1;
    program_register(jeo_pkg::REG_CIRCLE_SIZE, 32'(sz));
    program_register(jeo_pkg::REG_STEP_COUNT, 32'(st));
  endtask

  // Stimulus: directed plan, then random circles in three idling modes.
  initial begin
    int r;
    int mode;
    int quota;
    int eff;
    int len;
    int shift;
    int j;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < PLAN_LEN; r++) begin
      if (PLAN[r].kind == ROW_CFG) program_register(PLAN[r].reg_idx, PLAN[r].value);
      else send_item(PLAN[r].fresh, PLAN[r].typed, PLAN[r].want);
    end

    for (mode = 0; mode < 3; mode++) begin
      sender_idle = (mode == 0) ? 27 : (mode == 1) ? 70 : 0;
      quota = items_sent + ITEMS_PER_MODE;
      while (items_sent < quota) begin
        retune();
        repeat ($urandom_range(1, 3)) begin
          // A well-formed circle runs to empty and a little past it; now and then
          // a stray restart breaks it or the registers change in the middle.
          eff = (cfg_size > jeo_pkg::MAX_PEOPLE) ? jeo_pkg::MAX_PEOPLE : int'(cfg_size);
          len = eff - 1 + int'($urandom_range(0, 2));
          if (len < 0) len = 0;
          shift = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, len)) : -1;
          send_item(1'b1, 1'b0, UNTYPED);
          for (j = 0; j < len; j++) begin
            if (j == shift) retune();
            send_item($urandom_range(0, 19) == 0, 1'b0, UNTYPED);
          end
        end
      end
    end

    start <= 1'b0;
    while (removals_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Compares every result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (removals_due.size() == 0) begin
        note_mismatch('0, '{removed_person, last_removal, circle_empty});
      end else begin
        head_due = removals_due.pop_front();
        if (head_due.person !== removed_person || head_due.last !== last_removal ||
            head_due.empty !== circle_empty)
          note_mismatch(head_due, '{removed_person, last_removal, circle_empty});
      end
    end
  end

  // Ends the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire
